@@ hdl/tvp_pkg.sv @@
package tvp_pkg;

    localparam int VEL_W     = 26;
    localparam int ACC_W     = 18;
    localparam int LEN_W     = 48;
    localparam int MEAS_W    = 24;
    localparam int TICK_W    = 5;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 31;
    localparam int MUL_W     = 32;

    localparam logic signed [VEL_W-1:0] VEL_FLOOR = 26'sd150000;
    localparam logic signed [VEL_W-1:0] VEL_MAX   = 26'sh1FFFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN   = 26'sh2000000;
    localparam logic signed [LEN_W-1:0] LEN_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [LEN_W-1:0] LEN_MIN   = 48'sh8000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_VMUL,
        ST_VADD,
        ST_LMUL,
        ST_LADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RG_SPEED,
        RG_BRAKE,
        RG_STOP,
        RG_DONE
    } region_t;

    typedef enum logic [2:0] {
        PH_ACCEL    = 3'd0,
        PH_CRUISE   = 3'd1,
        PH_DECEL    = 3'd2,
        PH_CLAMP    = 3'd3,
        PH_COMPLETE = 3'd4,
        PH_STOP     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        REG_ACCEL_RATE = 3'd0,
        REG_DECEL_RATE = 3'd1,
        REG_MAX_VEL    = 3'd2,
        REG_FINAL_VEL  = 3'd3,
        REG_TARGET_LEN = 3'd4,
        REG_BRAKE_LEN  = 3'd5,
        REG_TICK       = 3'd6
    } cfg_idx_t;

endpackage

@@ hdl/trapezoidal_velocity_profile.sv @@
// Trapezoidal velocity profile generator, one request per control tick.
// The input channel (s_valid, s_ready, s_measured_length) carries the odometer
// length; each accepted request yields exactly one result on the output channel
// (m_valid, m_ready and the m_ payload): velocity, acceleration, integrated
// length in nm, the profile phase and an odometer clear flag.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata; the user must
// write them only while idle, as the block does not enforce it. One multiplier is
// shared between the velocity step (accel times tick) and the length step
// (velocity times tick). A request runs through classify, multiply, add, multiply,
// add and an output load; a completion skips the velocity multiply and add, and a
// stop at the end goes from classify to the output load. s_ready is high only in the
// idle state, after the last result is loaded. The output register frees the input
// side: a new request may be accepted while a finished result still waits for m_ready.
// If the receiver stalls with a result still held, the next request waits in
// its output load step until the register is free.
// aresetn is synchronous and active low: the profile state and the configuration
// registers clear to zero, except the tick period, which resets to 1 ms.
module trapezoidal_velocity_profile (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [tvp_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [tvp_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tvp_pkg::MEAS_W-1:0]     s_measured_length,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tvp_pkg::VEL_W-1:0]      m_velocity_cmd,
    output logic signed [tvp_pkg::ACC_W-1:0]      m_accel_cmd,
    output logic signed [tvp_pkg::LEN_W-1:0]      m_ideal_length,
    output logic [2:0]                            m_phase,
    output logic                                  m_reset_odometer
);
    import tvp_pkg::*;

    // configuration
    logic [16:0]              accel_rate_reg;
    logic signed [ACC_W-1:0]  decel_rate_reg;
    logic [23:0]              max_vel_reg;
    logic [23:0]              final_vel_reg;
    logic [22:0]              target_len_reg;
    logic [22:0]              brake_len_reg;
    logic [TICK_W-1:0]        tick_reg;

    // profile state
    state_t                   state_reg, state_next;
    region_t                  region_reg, region_next;
    phase_t                   phase_reg, phase_next;
    logic                     rst_odo_reg, rst_odo_next;
    logic signed [VEL_W-1:0]  velocity_reg, velocity_next;
    logic signed [ACC_W-1:0]  accel_reg, accel_next;
    logic signed [LEN_W-1:0]  length_reg, length_next;
    logic signed [MEAS_W-1:0] meas_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [VEL_W-1:0]  m_vel_reg;
    logic signed [ACC_W-1:0]  m_acc_reg;
    logic signed [LEN_W-1:0]  m_len_reg;
    phase_t                   m_phase_reg;
    logic                     m_rst_reg;

    logic                     out_free;
    logic                     load_out;
    logic signed [VEL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_full;
    logic signed [VEL_W-1:0]  remaining;
    logic                     speed_up;
    logic                     braking;
    logic signed [MUL_W-1:0]  vsum;
    logic signed [VEL_W-1:0]  vsat;
    logic signed [LEN_W:0]    lsum;
    logic signed [LEN_W-1:0]  lsat;
    logic signed [VEL_W-1:0]  max_vel_s;
    logic signed [VEL_W-1:0]  final_vel_s;

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;
    assign s_ready  = (state_reg == ST_IDLE);

    // Shared multiplier: acceleration in the velocity step, velocity otherwise.
    assign mul_a    = (state_reg == ST_VMUL)
                      ? {{(VEL_W-ACC_W){accel_reg[ACC_W-1]}}, accel_reg} : velocity_reg;
    assign mul_full = MUL_W'(mul_a) * MUL_W'($signed({1'b0, tick_reg}));

    assign remaining = $signed({3'b000, target_len_reg})
                     - $signed({{(VEL_W-MEAS_W){meas_reg[MEAS_W-1]}}, meas_reg});
    assign speed_up  = $signed({3'b000, brake_len_reg}) < remaining;
    assign braking   = meas_reg < $signed({1'b0, target_len_reg});

    assign vsum = $signed({{(MUL_W-VEL_W){velocity_reg[VEL_W-1]}}, velocity_reg})
                + $signed({prod_reg[PROD_W-1], prod_reg});
    assign lsum = $signed({length_reg[LEN_W-1], length_reg})
                + $signed({{(LEN_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    assign max_vel_s   = $signed({2'b00, max_vel_reg});
    assign final_vel_s = $signed({2'b00, final_vel_reg});

    always_comb begin
        if (vsum[MUL_W-1:VEL_W-1] == {(MUL_W-VEL_W+1){vsum[MUL_W-1]}}) begin
            vsat = vsum[VEL_W-1:0];
        end else begin
            vsat = vsum[MUL_W-1] ? VEL_MIN : VEL_MAX;
        end
        if (lsum[LEN_W] == lsum[LEN_W-1]) begin
            lsat = lsum[LEN_W-1:0];
        end else begin
            lsat = lsum[LEN_W] ? LEN_MIN : LEN_MAX;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (speed_up || braking) begin
                    state_next = ST_VMUL;
                end else if (final_vel_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LMUL;
                end
            end
            ST_VMUL: state_next = ST_VADD;
            ST_VADD: state_next = ST_LMUL;
            ST_LMUL: state_next = ST_LADD;
            ST_LADD: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        region_next   = region_reg;
        phase_next    = phase_reg;
        rst_odo_next  = rst_odo_reg;
        velocity_next = velocity_reg;
        accel_next    = accel_reg;
        length_next   = length_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: ;
            ST_CLASSIFY: begin
                rst_odo_next = 1'b0;
                if (speed_up) begin
                    region_next = RG_SPEED;
                    accel_next  = $signed({1'b0, accel_rate_reg});
                end else if (braking) begin
                    region_next = RG_BRAKE;
                    accel_next  = decel_rate_reg;
                end else if (final_vel_reg == '0) begin
                    region_next   = RG_STOP;
                    accel_next    = '0;
                    velocity_next = '0;
                    length_next   = '0;
                    phase_next    = PH_STOP;
                    rst_odo_next  = 1'b1;
                end else begin
                    region_next  = RG_DONE;
                    accel_next   = '0;
                    length_next  = '0;
                    phase_next   = PH_COMPLETE;
                    rst_odo_next = 1'b1;
                end
            end
            ST_VMUL, ST_LMUL: begin
                prod_next = mul_full[PROD_W-1:0];
            end
            ST_VADD: begin
                velocity_next = vsat;
                if (region_reg == RG_SPEED) begin
                    phase_next = PH_ACCEL;
                    if (vsat > max_vel_s) begin
                        velocity_next = max_vel_s;
                        accel_next    = '0;
                        phase_next    = PH_CRUISE;
                    end
                end else begin
                    phase_next = PH_DECEL;
                    // A stop brakes down to a floor; otherwise to the end velocity.
                    if (final_vel_reg == '0) begin
                        if (vsat < VEL_FLOOR) begin
                            velocity_next = VEL_FLOOR;
                            accel_next    = '0;
                            phase_next    = PH_CLAMP;
                        end
                    end else if (vsat < final_vel_s) begin
                        velocity_next = final_vel_s;
                        accel_next    = '0;
                        phase_next    = PH_CLAMP;
                    end
                end
            end
            ST_LADD: begin
                length_next = lsat;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            region_reg     <= RG_SPEED;
            phase_reg      <= PH_ACCEL;
            rst_odo_reg    <= 1'b0;
            velocity_reg   <= '0;
            accel_reg      <= '0;
            length_reg     <= '0;
            m_valid_reg    <= 1'b0;
            accel_rate_reg <= '0;
            decel_rate_reg <= '0;
            max_vel_reg    <= '0;
            final_vel_reg  <= '0;
            target_len_reg <= '0;
            brake_len_reg  <= '0;
            tick_reg       <= TICK_W'(1);
        end else begin
            state_reg    <= state_next;
            region_reg   <= region_next;
            phase_reg    <= phase_next;
            rst_odo_reg  <= rst_odo_next;
            velocity_reg <= velocity_next;
            accel_reg    <= accel_next;
            length_reg   <= length_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_ACCEL_RATE: accel_rate_reg <= cfg_wdata[16:0];
                    REG_DECEL_RATE: decel_rate_reg <= $signed(cfg_wdata[ACC_W-1:0]);
                    REG_MAX_VEL:    max_vel_reg    <= cfg_wdata;
                    REG_FINAL_VEL:  final_vel_reg  <= cfg_wdata;
                    REG_TARGET_LEN: target_len_reg <= cfg_wdata[22:0];
                    REG_BRAKE_LEN:  brake_len_reg  <= cfg_wdata[22:0];
                    REG_TICK:       tick_reg       <= cfg_wdata[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (s_valid && s_ready) begin
            meas_reg <= s_measured_length;
        end
        if (load_out) begin
            m_vel_reg   <= velocity_reg;
            m_acc_reg   <= accel_reg;
            m_len_reg   <= length_reg;
            m_phase_reg <= phase_reg;
            m_rst_reg   <= rst_odo_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_velocity_cmd   = m_vel_reg;
    assign m_accel_cmd      = m_acc_reg;
    assign m_ideal_length   = m_len_reg;
    assign m_phase          = m_phase_reg;
    assign m_reset_odometer = m_rst_reg;

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready after a request was accepted");

    a_clear_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reset_odometer |-> (m_phase == PH_COMPLETE || m_phase == PH_STOP))
        else $error("odometer clear outside the end of travel");

    a_stop_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == PH_STOP |-> m_velocity_cmd == '0 && m_ideal_length == '0)
        else $error("stop result with non-zero velocity or length");

    a_clamp_no_accel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_phase == PH_CRUISE || m_phase == PH_CLAMP || m_phase == PH_COMPLETE)
        |-> m_accel_cmd == '0)
        else $error("clamped or finished result with non-zero acceleration");

endmodule
